@@ sv/pacc_pkg.sv @@
// shared constants, codes and types for the pot axis conditioner
// used by the multiplier, divider, top level and testbench; depends on nothing
`default_nettype none

package pacc_pkg;

  localparam int ADC_BITS   = 10;
  localparam int FRAC_BITS  = 8;
  localparam int EMA_W      = ADC_BITS + FRAC_BITS;
  localparam int DIFF_W     = EMA_W + 1;
  localparam int ALPHA_W    = 9;
  localparam int ALPHA_FRAC = 8;
  localparam int PROD_W     = DIFF_W + ALPHA_W;
  localparam int STEP_W     = PROD_W - ALPHA_FRAC;
  localparam int AXIS_W     = 10;
  localparam int QUO_W      = AXIS_W;
  localparam int NUM_W      = 2 * AXIS_W;
  localparam int DEN2_W     = AXIS_W + 1;
  localparam int CNT_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [ADC_BITS-1:0] ADC_MAX    = {ADC_BITS{1'b1}};
  localparam logic [AXIS_W-1:0]   AXIS_MAX   = {AXIS_W{1'b1}};
  localparam logic [AXIS_W-1:0]   AXIS_MID   = AXIS_W'(512);
  localparam logic [AXIS_W-1:0]   AXIS_POS_Q = AXIS_W'(511);
  localparam logic [AXIS_W-1:0]   LAST_LO    = AXIS_W'(508);
  localparam logic [AXIS_W-1:0]   LAST_HI    = AXIS_W'(516);
  localparam logic [ALPHA_W-1:0]  ALPHA_ONE  = ALPHA_W'(256);
  localparam logic [PROD_W-1:0]   ALPHA_RND  = PROD_W'(128);
  localparam logic [EMA_W:0]      EMA_RND    = (EMA_W + 1)'(1 << (FRAC_BITS - 1));

  localparam logic [ADC_BITS-1:0]   CENTER_RST = ADC_BITS'(512);
  localparam logic [ALPHA_W-1:0]    ALPHA_RST  = ALPHA_W'(51);
  localparam logic [AXIS_W-1:0]     DZ_RST     = AXIS_W'(1);

  localparam logic [CFG_IDX_W-1:0] REG_CENTER   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_DEADZONE = CFG_IDX_W'(2);

  localparam logic [CNT_W-1:0] MUL_STEPS = CNT_W'(ALPHA_W);
  localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(QUO_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SPAN,
    ST_PREP,
    ST_DIV,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic                     done;
    logic signed [PROD_W-1:0] prod;
  } mac_res_t;

  typedef struct packed {
    logic             done;
    logic             ovf;
    logic [QUO_W-1:0] quo;
  } div_res_t;

endpackage

`default_nettype wire

@@ sv/pacc_mac.sv @@
// bit-serial shift-add multiplier for the moving average weight
// one weight bit per cycle; depends on pacc_pkg
`default_nettype none

module pacc_mac (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic [pacc_pkg::ALPHA_W-1:0]          alpha_i,
  input  logic signed [pacc_pkg::DIFF_W-1:0]    diff_i,
  output pacc_pkg::mac_res_t                    res_o
);
  import pacc_pkg::*;

  logic signed [PROD_W-1:0] mcand_q, mcand_d;
  logic signed [PROD_W-1:0] acc_q, acc_d;
  logic [ALPHA_W-1:0]       mplier_q, mplier_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic                     done_q, done_d;

  always_comb begin
    mcand_d  = mcand_q;
    acc_d    = acc_q;
    mplier_d = mplier_q;
    cnt_d    = cnt_q;
    done_d   = 1'b0;
    if (start_i) begin
      mcand_d  = PROD_W'(diff_i);
      mplier_d = alpha_i;
      acc_d    = '0;
      cnt_d    = MUL_STEPS;
    end else if (cnt_q != '0) begin
      if (mplier_q[0]) begin
        acc_d = acc_q + mcand_q;
      end
      mcand_d  = mcand_q <<< 1;
      mplier_d = mplier_q >> 1;
      cnt_d    = cnt_q - 1'b1;
      done_d   = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q  <= mcand_d;
    acc_q    <= acc_d;
    mplier_q <= mplier_d;
  end

  assign res_o.done = done_q;
  assign res_o.prod = acc_q;

endmodule

`default_nettype wire

@@ sv/pacc_div.sv @@
// restoring divider, one quotient bit per cycle, with overflow flag
// numerator bits shift in from a register; depends on pacc_pkg
`default_nettype none

module pacc_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [pacc_pkg::NUM_W-1:0]    num_i,
  input  logic [pacc_pkg::DEN2_W-1:0]   den2_i,
  output pacc_pkg::div_res_t            res_o
);
  import pacc_pkg::*;

  logic [DEN2_W-1:0] rem_q, rem_d;
  logic [DEN2_W-1:0] d2_q, d2_d;
  logic [QUO_W-1:0]  bits_q, bits_d;
  logic [QUO_W-1:0]  quo_q, quo_d;
  logic              ovf_q, ovf_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              done_q, done_d;
  logic [DEN2_W:0]   trial, trial_sub;
  logic              fits;

  assign trial     = {rem_q, bits_q[QUO_W-1]};
  assign fits      = trial >= {1'b0, d2_q};
  assign trial_sub = trial - {1'b0, d2_q};

  always_comb begin
    rem_d  = rem_q;
    d2_d   = d2_q;
    bits_d = bits_q;
    quo_d  = quo_q;
    ovf_d  = ovf_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = {1'b0, num_i[NUM_W-1:QUO_W]};
      ovf_d  = {1'b0, num_i[NUM_W-1:QUO_W]} >= den2_i;
      bits_d = num_i[QUO_W-1:0];
      d2_d   = den2_i;
      quo_d  = '0;
      cnt_d  = DIV_STEPS;
    end else if (cnt_q != '0) begin
      rem_d  = fits ? trial_sub[DEN2_W-1:0] : trial[DEN2_W-1:0];
      quo_d  = {quo_q[QUO_W-2:0], fits};
      bits_d = bits_q << 1;
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    d2_q   <= d2_d;
    bits_q <= bits_d;
    quo_q  <= quo_d;
    ovf_q  <= ovf_d;
  end

  assign res_o.done = done_q;
  assign res_o.ovf  = ovf_q;
  assign res_o.quo  = quo_q;

endmodule

`default_nettype wire

@@ sv/pot_axis_autocal_conditioner_unit.sv @@
// top level of the pot axis conditioner: median, moving average, calibration,
// scaling and report decision; depends on pacc_pkg, pacc_mac and pacc_div
//
// usage
//   s_axis carries one item per converter tick: three raw samples in tdata.
//   m_axis returns one item per input item: the axis value in tdata and the
//   report flag in tuser. the receiver's report flag marks a value that
//   becomes the new last reported value.
//   cfg writes center, filter weight and deadzone by index; cfg_ready_o is
//   always high and an unknown index is dropped. write only while idle.
// sequence
//   one item at a time: a new item is taken only in IDLE, after the previous
//   one has passed MUL, SPAN, PREP, DIV and FIN in turn. the work is set by
//   the nine steps of the serial multiplier and the ten quotient steps plus
//   load of the serial divider.
// reset
//   filter, min/max tracking and report history clear; registers return to
//   center 512, weight 51, deadzone 1.
// stall
//   a finished result waits in the output register; the next input item is
//   still taken, and its result is held back until the output is free.
`default_nettype none

module pot_axis_autocal_conditioner_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [31:0]                          s_axis_tdata,  // sample_a, sample_b, sample_c, pad
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [15:0]                          m_axis_tdata,  // axis_value, pad
  output logic                                 m_axis_tuser,  // send_report
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [pacc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [pacc_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import pacc_pkg::*;

  state_e state_q, state_d;

  logic [ADC_BITS-1:0] center_q, center_d;
  logic [ALPHA_W-1:0]  alpha_q, alpha_d;
  logic [AXIS_W-1:0]   dz_q, dz_d;

  logic [EMA_W-1:0]    ema_q, ema_d;
  logic [ADC_BITS-1:0] min_q, min_d;
  logic [ADC_BITS-1:0] max_q, max_d;
  logic [AXIS_W-1:0]   last_q, last_d;
  logic                once_q, once_d;

  logic [ADC_BITS-1:0] med_q, med_d;
  logic                direct_q, direct_d;
  logic [ADC_BITS-1:0] f_q, f_d;
  logic                neg_q, neg_d;

  logic                out_valid_q, out_valid_d;
  logic [AXIS_W-1:0]   out_axis_q, out_axis_d;
  logic                out_send_q, out_send_d;

  logic accept, div_start, fin_load;

  logic [ADC_BITS-1:0] smp_a, smp_b, smp_c, lo_ab, hi_ab, hi_lo, median;
  logic signed [DIFF_W-1:0] mac_diff;
  mac_res_t mac_res;
  div_res_t div_res;

  logic signed [PROD_W-1:0] prod_rnd;
  logic signed [STEP_W-1:0] ema_step, ema_sum;
  logic [EMA_W:0]           f_sum;
  logic [ADC_BITS:0]        f_full;
  logic [ADC_BITS-1:0]      f_new;

  logic [ADC_BITS:0]   d_w, spos_w, sneg_w;
  logic [ADC_BITS-1:0] d_mag, spos, sneg, den;
  logic [NUM_W-2:0]    num_half;
  logic [NUM_W-1:0]    num_n;
  logic [DEN2_W-1:0]   den2;

  logic [AXIS_W-1:0]   axis;
  logic [AXIS_W:0]     dl, dl_neg;
  logic [AXIS_W-1:0]   adiff;
  logic                send;

  // median of three
  assign smp_a  = s_axis_tdata[ADC_BITS-1:0];
  assign smp_b  = s_axis_tdata[2*ADC_BITS-1:ADC_BITS];
  assign smp_c  = s_axis_tdata[3*ADC_BITS-1:2*ADC_BITS];
  assign lo_ab  = (smp_a < smp_b) ? smp_a : smp_b;
  assign hi_ab  = (smp_a < smp_b) ? smp_b : smp_a;
  assign hi_lo  = (hi_ab < smp_c) ? hi_ab : smp_c;
  assign median = (lo_ab > hi_lo) ? lo_ab : hi_lo;

  assign accept   = s_axis_tvalid & s_axis_tready;
  assign mac_diff = $signed({1'b0, median, {FRAC_BITS{1'b0}}}) - $signed({1'b0, ema_q});

  pacc_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .alpha_i (alpha_q),
    .diff_i  (mac_diff),
    .res_o   (mac_res)
  );

  // filter update
  assign prod_rnd = mac_res.prod + ALPHA_RND;
  assign ema_step = prod_rnd[PROD_W-1:ALPHA_FRAC];
  assign ema_sum  = $signed(STEP_W'(ema_q)) + ema_step;

  // rounded average
  assign f_sum  = {1'b0, ema_q} + EMA_RND;
  assign f_full = f_sum[EMA_W:FRAC_BITS];
  assign f_new  = (f_full > {1'b0, ADC_MAX}) ? ADC_MAX : f_full[ADC_BITS-1:0];

  // spans and divider operands
  assign d_w      = {1'b0, f_q} - {1'b0, center_q};
  assign d_mag    = d_w[ADC_BITS] ? ADC_BITS'(-d_w) : d_w[ADC_BITS-1:0];
  assign spos_w   = {1'b0, max_q} - {1'b0, center_q};
  assign sneg_w   = {1'b0, center_q} - {1'b0, min_q};
  assign spos     = (spos_w[ADC_BITS] || spos_w == '0) ? ADC_BITS'(1) : spos_w[ADC_BITS-1:0];
  assign sneg     = (sneg_w[ADC_BITS] || sneg_w == '0) ? ADC_BITS'(1) : sneg_w[ADC_BITS-1:0];
  assign den      = d_w[ADC_BITS] ? sneg : spos;
  assign num_half = d_w[ADC_BITS] ? {d_mag, 9'b0}
                                  : {d_mag, 9'b0} - (NUM_W - 1)'(d_mag);
  assign num_n    = {num_half, 1'b0} + NUM_W'(den);
  assign den2     = {den, 1'b0};

  pacc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_n),
    .den2_i  (den2),
    .res_o   (div_res)
  );

  // axis value and report decision
  always_comb begin
    if (!neg_q) begin
      axis = (div_res.ovf || div_res.quo >= AXIS_POS_Q) ? AXIS_MAX : AXIS_MID + div_res.quo;
    end else begin
      axis = (div_res.ovf || div_res.quo > AXIS_MID) ? '0 : AXIS_MID - div_res.quo;
    end
  end

  assign dl     = {1'b0, axis} - {1'b0, last_q};
  assign dl_neg = -dl;
  assign adiff  = dl[AXIS_W] ? dl_neg[AXIS_W-1:0] : dl[AXIS_W-1:0];
  assign send   = !once_q || (adiff >= dz_q)
                  || (last_q >= LAST_LO && last_q <= LAST_HI && adiff != '0);

  // fsm next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_MUL;
      ST_MUL:  if (mac_res.done) state_d = ST_SPAN;
      ST_SPAN: state_d = ST_PREP;
      ST_PREP: state_d = ST_DIV;
      ST_DIV:  if (div_res.done) state_d = ST_FIN;
      ST_FIN:  if (fin_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    fin_load      = 1'b0;
    case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_PREP: div_start = 1'b1;
      ST_FIN:  fin_load = !out_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  // configuration
  always_comb begin
    center_d = center_q;
    alpha_d  = alpha_q;
    dz_d     = dz_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_CENTER:   center_d = cfg_data_i[ADC_BITS-1:0];
        REG_ALPHA:    alpha_d = (cfg_data_i[ALPHA_W-1:0] > ALPHA_ONE) ? ALPHA_ONE
                                                                      : cfg_data_i[ALPHA_W-1:0];
        REG_DEADZONE: dz_d = cfg_data_i[AXIS_W-1:0];
        default: ;
      endcase
    end
  end

  // datapath state
  always_comb begin
    med_d       = med_q;
    direct_d    = direct_q;
    ema_d       = ema_q;
    f_d         = f_q;
    min_d       = min_q;
    max_d       = max_q;
    neg_d       = neg_q;
    last_d      = last_q;
    once_d      = once_q;
    out_axis_d  = out_axis_q;
    out_send_d  = out_send_q;
    out_valid_d = out_valid_q & ~m_axis_tready;
    if (accept) begin
      med_d    = median;
      direct_d = (ema_q == '0) && (median != '0);
    end
    if (state_q == ST_MUL && mac_res.done) begin
      ema_d = direct_q ? {med_q, {FRAC_BITS{1'b0}}} : ema_sum[EMA_W-1:0];
    end
    if (state_q == ST_SPAN) begin
      f_d = f_new;
      if (f_new < min_q) min_d = f_new;
      if (f_new > max_q) max_d = f_new;
    end
    if (div_start) begin
      neg_d = d_w[ADC_BITS];
    end
    if (fin_load) begin
      out_valid_d = 1'b1;
      out_axis_d  = axis;
      out_send_d  = send;
      if (send) begin
        last_d = axis;
        once_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      center_q    <= CENTER_RST;
      alpha_q     <= ALPHA_RST;
      dz_q        <= DZ_RST;
      ema_q       <= '0;
      min_q       <= ADC_MAX;
      max_q       <= '0;
      last_q      <= '0;
      once_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      center_q    <= center_d;
      alpha_q     <= alpha_d;
      dz_q        <= dz_d;
      ema_q       <= ema_d;
      min_q       <= min_d;
      max_q       <= max_d;
      last_q      <= last_d;
      once_q      <= once_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    med_q      <= med_d;
    direct_q   <= direct_d;
    f_q        <= f_d;
    neg_q      <= neg_d;
    out_axis_q <= out_axis_d;
    out_send_q <= out_send_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(16 - AXIS_W){1'b0}}, out_axis_q};
  assign m_axis_tuser  = out_send_q;
  assign cfg_ready_o   = 1'b1;

endmodule

`default_nettype wire

@@ sv/pacc_checker.sv @@
// port-level assertions for the pot axis conditioner, bound to the top level
// sees only the top level's ports
`default_nettype none

module pacc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output item changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("input taken again while an item is in work");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared without an item in work");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[15:10] == 6'd0)
    else $error("axis value out of range");

endmodule

bind pot_axis_autocal_conditioner_unit pacc_checker u_pacc_checker (.*);

`default_nettype wire

@@ tb/testbench.sv @@
// self-checking testbench for pot_axis_autocal_conditioner_unit
// a scoreboard class predicts the median, filter, calibration, scaling and report flag
// of every item; depends on pacc_pkg and the unit only
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pacc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 40;
  localparam int SEGMENTS     = 7;
  localparam int SEG_ITEMS    = 200;

  typedef struct packed {
    logic [AXIS_W-1:0] axis;
    logic              send;
  } axis_result_t;

  class axis_scoreboard;
    logic [ADC_BITS-1:0] center;
    logic [ALPHA_W-1:0]  alpha;
    logic [AXIS_W-1:0]   deadzone;
    logic [EMA_W-1:0]    ema;
    logic [ADC_BITS-1:0] lo_seen;
    logic [ADC_BITS-1:0] hi_seen;
    logic [AXIS_W-1:0]   last_sent;
    bit                  sent_any;
    axis_result_t        expected_q[$];
    int                  errors;
    int                  results;
    int                  reports;

    function new();
      center    = CENTER_RST;
      alpha     = ALPHA_RST;
      deadzone  = DZ_RST;
      ema       = '0;
      lo_seen   = ADC_MAX;
      hi_seen   = '0;
      last_sent = '0;
      sent_any  = 1'b0;
      errors    = 0;
      results   = 0;
      reports   = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_CENTER:   center = data[ADC_BITS-1:0];
        REG_ALPHA:    alpha = (data[ALPHA_W-1:0] > ALPHA_ONE) ? ALPHA_ONE : data[ALPHA_W-1:0];
        REG_DEADZONE: deadzone = data[AXIS_W-1:0];
        default: ;
      endcase
    endfunction

    task note_tick(input logic [ADC_BITS-1:0] a, b, c);
      logic [ADC_BITS-1:0] med;
      longint       sum, fval, offset, span_pos, span_neg, pos, gap;
      bit           send;
      axis_result_t item;
      if ((a >= b && a <= c) || (a >= c && a <= b)) med = a;
      else if ((b >= a && b <= c) || (b >= c && b <= a)) med = b;
      else med = c;
      if (ema == 0 && med != 0) begin
        ema = EMA_W'(med) << FRAC_BITS;
      end else begin
        sum = longint'(alpha) * (longint'(med) << FRAC_BITS)
            + (longint'(ALPHA_ONE) - longint'(alpha)) * longint'(ema);
        ema = EMA_W'((sum + 128) >> ALPHA_FRAC);
      end
      fval = (longint'(ema) + (longint'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      if (fval > longint'(ADC_MAX)) fval = longint'(ADC_MAX);
      if (fval < longint'(lo_seen)) lo_seen = ADC_BITS'(fval);
      if (fval > longint'(hi_seen)) hi_seen = ADC_BITS'(fval);
      offset   = fval - longint'(center);
      span_neg = longint'(center) - longint'(lo_seen);
      span_pos = longint'(hi_seen) - longint'(center);
      if (span_neg < 1) span_neg = 1;
      if (span_pos < 1) span_pos = 1;
      if (offset >= 0)
        pos = longint'(AXIS_MID)
            + (2 * offset * longint'(AXIS_POS_Q) + span_pos) / (2 * span_pos);
      else
        pos = longint'(AXIS_MID)
            - (2 * (-offset) * longint'(AXIS_MID) + span_neg) / (2 * span_neg);
      if (pos < 0) pos = 0;
      if (pos > longint'(AXIS_MAX)) pos = longint'(AXIS_MAX);
      gap = pos - longint'(last_sent);
      if (gap < 0) gap = -gap;
      send = !sent_any || gap >= longint'(deadzone)
          || (last_sent >= LAST_LO && last_sent <= LAST_HI && gap >= 1);
      if (send) begin
        last_sent = AXIS_W'(pos);
        sent_any  = 1'b1;
      end
      item.axis = AXIS_W'(pos);
      item.send = send;
      expected_q.push_back(item);
    endtask

    task report_mismatch(input string what);
      errors++;
      $display("mismatch at result %0d: %s", results, what);
    endtask

    task check_result(input logic [AXIS_W-1:0] axis, input logic send);
      axis_result_t item;
      results++;
      if (send === 1'b1) reports++;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected item, axis %0d report %b", axis, send));
        return;
      end
      item = expected_q.pop_front();
      if (axis !== item.axis)
        report_mismatch($sformatf("axis_value %0d, predicted %0d", axis, item.axis));
      if (send !== item.send)
        report_mismatch($sformatf("send_report %b, predicted %b", send, item.send));
    endtask
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [31:0]           s_axis_tdata = '0;  // sample_a, sample_b, sample_c, pad
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [15:0]           m_axis_tdata;       // axis_value, pad
  logic                  m_axis_tuser;       // send_report
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  axis_scoreboard sb = new();
  int send_idle_pct = 33;
  int recv_idle_pct = 81;
  int hold_cycles = 0;
  int settings_count = 0;
  int cycle_count = 0;

  pot_axis_autocal_conditioner_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("run stopped at cycle limit with %0d results pending", sb.expected_q.size());
      $display("testbench: errors");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off when requested
  initial begin
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata[AXIS_W-1:0], m_axis_tuser);
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
    end
  end

  function automatic logic [ADC_BITS-1:0] clip_sample(int v);
    if (v < 0) return '0;
    if (v > int'(ADC_MAX)) return ADC_MAX;
    return ADC_BITS'(v);
  endfunction

  task automatic push_tick(input logic [ADC_BITS-1:0] a, b, c);
    if (send_idle_pct != 0) begin
      while ($urandom_range(99, 0) < send_idle_pct) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tdata  <= {2'b00, c, b, a};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_tick(a, b, c);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_register(idx, data);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] ctr, alpha_data, dz, input bit stray);
    write_reg(REG_CENTER, ctr);
    write_reg(REG_ALPHA, alpha_data);
    write_reg(REG_DEADZONE, dz);
    if (stray) write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    cfg_valid_i <= 1'b0;
    settings_count++;
    @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // mostly a drifting pot with jitter, some wild samples, random ticks and rail values
  task automatic run_random(input int count);
    int                  level;
    int                  kind;
    logic [ADC_BITS-1:0] s[3];
    level = $urandom_range(1023, 0);
    repeat (count) begin
      kind = $urandom_range(99, 0);
      if ($urandom_range(39, 0) == 0) level = $urandom_range(1023, 0);
      else level = clip_sample(level + int'($urandom_range(24, 0)) - 12);
      for (int k = 0; k < 3; k++) s[k] = clip_sample(level + int'($urandom_range(6, 0)) - 3);
      if (kind >= 70 && kind < 85) begin
        s[$urandom_range(2, 0)] = ADC_BITS'($urandom_range(1023, 0));
      end else if (kind >= 85 && kind < 95) begin
        for (int k = 0; k < 3; k++) s[k] = ADC_BITS'($urandom_range(1023, 0));
      end else if (kind >= 95) begin
        for (int k = 0; k < 3; k++) s[k] = $urandom_range(1, 0) ? ADC_MAX : '0;
      end
      push_tick(s[0], s[1], s[2]);
    end
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] ctr, alpha_data, dz;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: zero median first, rails, median from each position
    push_tick(0, 0, 0);
    push_tick(1023, 1023, 1023);
    push_tick(500, 0, 1023);
    push_tick(0, 500, 1023);
    push_tick(1023, 0, 500);
    push_tick(7, 7, 900);
    drain();

    // centre at top, weight above one, zero deadzone, stray index
    configure(1023, 10'h3FF, 0, 1'b1);
    push_tick(0, 0, 0);
    push_tick(5, 5, 5);
    push_tick(1023, 1023, 1023);
    push_tick(600, 600, 600);
    push_tick(0, 0, 0);
    drain();

    // centre at bottom, frozen filter, widest deadzone
    configure(0, 0, 1023, 1'b0);
    push_tick(1023, 1023, 1023);
    push_tick(10, 10, 10);
    push_tick(0, 0, 0);
    push_tick(512, 512, 512);
    drain();

    configure(300, 256, 3, 1'b0);
    push_tick(800, 800, 800);
    push_tick(250, 250, 250);
    push_tick(511, 511, 511);
    drain();

    // last value near centre with a wide deadzone
    configure(512, 300, 1023, 1'b1);
    push_tick(512, 512, 512);
    push_tick(513, 513, 513);
    push_tick(514, 1023, 0);
    drain();

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg < 2) begin
        send_idle_pct = 33;
        recv_idle_pct = 81;
      end else if (seg < 4) begin
        send_idle_pct = 81;
        recv_idle_pct = 33;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      ctr = (seg % 3 == 0) ? CFG_DATA_W'(CENTER_RST) : CFG_DATA_W'($urandom_range(1023, 0));
      alpha_data = $urandom_range(1, 0) ? CFG_DATA_W'($urandom_range(1023, 0))
                                        : CFG_DATA_W'($urandom_range(96, 1));
      dz = ($urandom_range(3, 0) == 0) ? CFG_DATA_W'($urandom_range(1023, 0))
                                       : CFG_DATA_W'($urandom_range(12, 0));
      configure(ctr, alpha_data, dz, $urandom_range(1, 0));
      if (seg == 4) hold_cycles = 400;
      run_random(SEG_ITEMS);
      drain();
    end

    if (sb.expected_q.size() != 0)
      sb.report_mismatch($sformatf("%0d predicted items never arrived", sb.expected_q.size()));
    $display("summary: %0d items checked, %0d flagged for report, %0d register settings",
             sb.results, sb.reports, settings_count);
    $display("summary: rails, median positions, filter reload, span limits, long output stall");
    if (sb.errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
